### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property while the block is out of reset.
`define QCGS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks a property on every edge, reset included.
`define QCGS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/qcgs_pkg.sv
package qcgs_pkg;

   localparam int LEG_COUNT    = 4;
   localparam int ACTION_COUNT = 6;
   localparam int CSR_INDEX_W  = 3;

   typedef logic signed [7:0] foot_type;
   typedef logic signed [1:0] dir_type;
   typedef logic [2:0]        leg_type;
   typedef logic [2:0]        action_type;
   typedef logic [1:0]        substep_type;
   typedef logic [7:0]        angle_type;

   // Command codes of an input item.
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_SET_DIR = 1'b1;

   // Stored walking directions.
   localparam dir_type DIR_STOP = 2'sb00;
   localparam dir_type DIR_FWD  = 2'sb01;
   localparam dir_type DIR_BACK = 2'sb11;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STAND_KNEE_LEG0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAND_KNEE_LEG3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS      = 3'd4;

   localparam leg_type     NO_LEG      = 3'd7;
   localparam action_type  LAST_ACTION = action_type'(ACTION_COUNT - 1);
   localparam substep_type SUB_LIFT    = 2'd0;
   localparam substep_type SUB_SWING   = 2'd1;
   localparam substep_type SUB_PLANT   = 2'd2;

   localparam logic signed [8:0] SHIFT_DIST = 9'sd20;
   localparam logic signed [8:0] FOOT_LIMIT = 9'sd120;
   localparam foot_type          SWING_DIST = 8'sd40;
   localparam logic signed [9:0] HIP_CENTER = 10'sd90;
   localparam logic signed [9:0] HIP_LOW    = 10'sd10;
   localparam logic signed [9:0] HIP_HIGH   = 10'sd170;
   localparam logic [8:0]        LIFT_DEG   = 9'd30;
   localparam logic [8:0]        KNEE_TOP   = 9'd85;

   // Bit i is set where leg i's hip turns the same way as its foot offset.
   localparam logic [LEG_COUNT-1:0] SIDE_POSITIVE = 4'b1001;

   localparam angle_type STAND_KNEE_RESET = 8'd60;
   localparam angle_type HOLD_TICKS_RESET = 8'd5;

   typedef struct packed {
      foot_type [LEG_COUNT-1:0] foot;
      leg_type                  raised;
      dir_type                  walk_dir;
      action_type               action;
      substep_type              substep;
      logic [7:0]               hold;
   } gait_state_type;

   typedef struct packed {
      angle_type [LEG_COUNT-1:0] hip;
      angle_type [LEG_COUNT-1:0] knee;
      logic                      walking;
   } pose_type;

   function automatic logic is_shift(input action_type a);
      return (a == 3'd2) || (a == 3'd5);
   endfunction

   // Leg stepped by each action of the cycle; shifts move all legs.
   function automatic leg_type action_leg(input action_type a);
      leg_type leg;
      unique case (a)
         3'd0:    leg = 3'd3;
         3'd3:    leg = 3'd1;
         3'd4:    leg = 3'd2;
         default: leg = 3'd0;
      endcase
      return leg;
   endfunction

endpackage

### rtl/qcgs_if.sv
interface qcgs_req_if;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic signed [1:0]     direction;

   modport source (output valid, output cmd, output direction, input ready);
   modport sink   (input valid, input cmd, input direction, output ready);
endinterface

interface qcgs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] hip_leg0;
   logic [7:0] hip_leg1;
   logic [7:0] hip_leg2;
   logic [7:0] hip_leg3;
   logic [7:0] knee_leg0;
   logic [7:0] knee_leg1;
   logic [7:0] knee_leg2;
   logic [7:0] knee_leg3;
   logic       walking;

   modport source (output valid, output hip_leg0, output hip_leg1, output hip_leg2,
                   output hip_leg3, output knee_leg0, output knee_leg1, output knee_leg2,
                   output knee_leg3, output walking, input ready);
   modport sink   (input valid, input hip_leg0, input hip_leg1, input hip_leg2,
                   input hip_leg3, input knee_leg0, input knee_leg1, input knee_leg2,
                   input knee_leg3, input walking, output ready);
endinterface

interface qcgs_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

### rtl/qcgs_step.sv
module qcgs_step (
   input  qcgs_pkg::gait_state_type cur_state,
   input  logic                     cmd,
   input  qcgs_pkg::dir_type        direction,
   input  qcgs_pkg::angle_type      hold_ticks,
   output qcgs_pkg::gait_state_type next_state
);

   qcgs_pkg::dir_type   dir_new;
   qcgs_pkg::leg_type   leg;
   logic                shift;
   logic signed [8:0]   shift_amt;
   logic signed [8:0]   moved [qcgs_pkg::LEG_COUNT];

   assign leg       = qcgs_pkg::action_leg(cur_state.action);
   assign shift     = qcgs_pkg::is_shift(cur_state.action);
   assign shift_amt = (cur_state.walk_dir == qcgs_pkg::DIR_FWD) ?
                      qcgs_pkg::SHIFT_DIST : -qcgs_pkg::SHIFT_DIST;

   // Code 2 (-2) saturates to walking back.
   always_comb begin
      unique case (direction)
         qcgs_pkg::DIR_STOP: dir_new = qcgs_pkg::DIR_STOP;
         qcgs_pkg::DIR_FWD:  dir_new = qcgs_pkg::DIR_FWD;
         default:            dir_new = qcgs_pkg::DIR_BACK;
      endcase
   end

   // Every foot moves against the walking direction, held within the reach limit.
   always_comb begin
      for (int i = 0; i < qcgs_pkg::LEG_COUNT; i++) begin
         moved[i] = {cur_state.foot[i][7], cur_state.foot[i]} - shift_amt;
         if (moved[i] > qcgs_pkg::FOOT_LIMIT) begin
            moved[i] = qcgs_pkg::FOOT_LIMIT;
         end else if (moved[i] < -qcgs_pkg::FOOT_LIMIT) begin
            moved[i] = -qcgs_pkg::FOOT_LIMIT;
         end
      end
   end

   always_comb begin
      next_state = cur_state;
      priority if (cmd == qcgs_pkg::CMD_SET_DIR) begin
         if (cur_state.walk_dir == qcgs_pkg::DIR_STOP && dir_new != qcgs_pkg::DIR_STOP) begin
            next_state.action  = '0;
            next_state.substep = qcgs_pkg::SUB_LIFT;
            next_state.hold    = '0;
         end
         next_state.walk_dir = dir_new;
      end else if (cur_state.walk_dir == qcgs_pkg::DIR_STOP) begin
         next_state.raised = qcgs_pkg::NO_LEG;
      end else if (cur_state.hold != 8'd0) begin
         next_state.hold = cur_state.hold - 8'd1;
      end else begin
         if (shift) begin
            for (int i = 0; i < qcgs_pkg::LEG_COUNT; i++) begin
               next_state.foot[i] = moved[i][7:0];
            end
         end else begin
            unique case (cur_state.substep)
               qcgs_pkg::SUB_LIFT:  next_state.raised = leg;
               qcgs_pkg::SUB_SWING: next_state.foot[leg[1:0]] =
                  (cur_state.walk_dir == qcgs_pkg::DIR_FWD) ?
                  qcgs_pkg::SWING_DIST : -qcgs_pkg::SWING_DIST;
               default:             next_state.raised = qcgs_pkg::NO_LEG;
            endcase
         end
         next_state.hold = hold_ticks;
         if (shift || cur_state.substep == qcgs_pkg::SUB_PLANT) begin
            next_state.substep = qcgs_pkg::SUB_LIFT;
            next_state.action  = (cur_state.action == qcgs_pkg::LAST_ACTION) ?
                                 '0 : cur_state.action + 3'd1;
         end else begin
            next_state.substep = cur_state.substep + 2'd1;
         end
      end
   end

endmodule

### rtl/qcgs_render.sv
module qcgs_render (
   input  qcgs_pkg::gait_state_type                      state,
   input  qcgs_pkg::angle_type [qcgs_pkg::LEG_COUNT-1:0] stand_knee,
   output qcgs_pkg::pose_type                            pose
);

   logic signed [9:0] foot_ext [qcgs_pkg::LEG_COUNT];
   logic signed [9:0] hip_raw  [qcgs_pkg::LEG_COUNT];
   logic [8:0]        lifted   [qcgs_pkg::LEG_COUNT];

   always_comb begin
      pose.walking = (state.walk_dir != qcgs_pkg::DIR_STOP);
      for (int i = 0; i < qcgs_pkg::LEG_COUNT; i++) begin
         foot_ext[i] = {{2{state.foot[i][7]}}, state.foot[i]};
         hip_raw[i]  = qcgs_pkg::SIDE_POSITIVE[i] ? qcgs_pkg::HIP_CENTER + foot_ext[i] :
                                                    qcgs_pkg::HIP_CENTER - foot_ext[i];
         if (hip_raw[i] < qcgs_pkg::HIP_LOW) begin
            pose.hip[i] = qcgs_pkg::HIP_LOW[7:0];
         end else if (hip_raw[i] > qcgs_pkg::HIP_HIGH) begin
            pose.hip[i] = qcgs_pkg::HIP_HIGH[7:0];
         end else begin
            pose.hip[i] = hip_raw[i][7:0];
         end

         // The lifted knee saturates at the top angle, even below the planted one.
         lifted[i] = {1'b0, stand_knee[i]} + qcgs_pkg::LIFT_DEG;
         if (state.raised == qcgs_pkg::leg_type'(i)) begin
            pose.knee[i] = (lifted[i] > qcgs_pkg::KNEE_TOP) ? qcgs_pkg::KNEE_TOP[7:0] :
                                                              lifted[i][7:0];
         end else begin
            pose.knee[i] = stand_knee[i];
         end
      end
   end

endmodule

### rtl/quadruped_creep_gait_sequencer.sv
// Channel   Modport  Payload                                   Purpose
// req_bus   sink     cmd, direction                            tick or set-direction item
// rsp_bus   source   hip_leg0..3, knee_leg0..3, walking        pose for every tick item
// csr_bus   sink     index, wdata                              stand knees and hold ticks
//
// An item is latched in an input register and evaluated there against the gait state;
// a tick's pose then goes through the result register before it is offered on rsp_bus.
// One item per cycle is sustained unless a tick is stalled; the throughput is set by the
// single evaluation stage. A stalled result holds it only if the waiting item is a tick.
// Reset is synchronous and active high; it restores the register defaults and a
// standing pose with all feet centered.
`include "assert_macros.svh"

module quadruped_creep_gait_sequencer (
   input logic             clock,
   input logic             reset,
   qcgs_req_if.sink        req_bus,
   qcgs_rsp_if.source      rsp_bus,
   qcgs_csr_if.sink        csr_bus
);

   // Input register.
   logic                     in_valid_ff, in_valid_in;
   logic                     cmd_ff;
   qcgs_pkg::dir_type        dir_ff;

   // Gait state and configuration.
   qcgs_pkg::gait_state_type                      state_ff, state_in;
   qcgs_pkg::angle_type [qcgs_pkg::LEG_COUNT-1:0] stand_knee_ff;
   qcgs_pkg::angle_type                           hold_ticks_ff;

   // Result register.
   logic                     out_valid_ff, out_valid_in;
   qcgs_pkg::pose_type       pose_ff, pose;

   logic has_result;
   logic advance;
   logic accept;

   // Terms used by the checks at the end.
   logic substep_ok;
   logic set_advance;
   logic out_held;

   // A tick item needs a free result slot; a set-direction item never waits.
   assign has_result  = in_valid_ff && (cmd_ff == qcgs_pkg::CMD_TICK);
   assign advance     = in_valid_ff && (!has_result || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept      = req_bus.valid && req_bus.ready;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_comb begin
      if (advance && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   qcgs_step u_step (
      .cur_state  (state_ff),
      .cmd        (cmd_ff),
      .direction  (dir_ff),
      .hold_ticks (hold_ticks_ff),
      .next_state (state_in)
   );

   // The pose shows the state as it stands after this item's update.
   qcgs_render u_render (
      .state      (state_in),
      .stand_knee (stand_knee_ff),
      .pose       (pose)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < qcgs_pkg::LEG_COUNT; i++) begin
            state_ff.foot[i] <= '0;
         end
         state_ff.raised   <= qcgs_pkg::NO_LEG;
         state_ff.walk_dir <= qcgs_pkg::DIR_STOP;
         state_ff.action   <= '0;
         state_ff.substep  <= qcgs_pkg::SUB_LIFT;
         state_ff.hold     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_bus.cmd;
         dir_ff <= req_bus.direction;
      end
      if (advance && has_result) begin
         pose_ff <= pose;
      end
   end

   // Configuration writes land at once; indexes past the hold register are dropped.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qcgs_pkg::LEG_COUNT; i++) begin
            stand_knee_ff[i] <= qcgs_pkg::STAND_KNEE_RESET;
         end
         hold_ticks_ff <= qcgs_pkg::HOLD_TICKS_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index <= qcgs_pkg::CSR_STAND_KNEE_LEG3) begin
            stand_knee_ff[csr_bus.index[1:0] - qcgs_pkg::CSR_STAND_KNEE_LEG0[1:0]] <=
               csr_bus.wdata;
         end else if (csr_bus.index == qcgs_pkg::CSR_HOLD_TICKS) begin
            hold_ticks_ff <= csr_bus.wdata;
         end
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.hip_leg0  = pose_ff.hip[0];
   assign rsp_bus.hip_leg1  = pose_ff.hip[1];
   assign rsp_bus.hip_leg2  = pose_ff.hip[2];
   assign rsp_bus.hip_leg3  = pose_ff.hip[3];
   assign rsp_bus.knee_leg0 = pose_ff.knee[0];
   assign rsp_bus.knee_leg1 = pose_ff.knee[1];
   assign rsp_bus.knee_leg2 = pose_ff.knee[2];
   assign rsp_bus.knee_leg3 = pose_ff.knee[3];
   assign rsp_bus.walking   = pose_ff.walking;

   assign substep_ok  = !qcgs_pkg::is_shift(state_ff.action) &&
                        (state_ff.substep <= qcgs_pkg::SUB_PLANT);
   assign set_advance = advance && !has_result;
   assign out_held    = out_valid_ff && !rsp_bus.ready;

   // The action counter wraps after the last action of the cycle.
   `QCGS_ASSERT(a_action_range, state_ff.action <= qcgs_pkg::LAST_ACTION, "bad action index")

   // Shifts have a single substep, and steps never pass the plant substep.
   `QCGS_ASSERT(a_substep_shape, (state_ff.substep != qcgs_pkg::SUB_LIFT) |-> substep_ok, "bad substep")

   // A set-direction item produces no result.
   `QCGS_ASSERT(a_no_result_on_set, set_advance |=> (out_valid_ff == $past(out_held)), "set made a pose")

   // Reset leaves both pipeline registers empty.
   `QCGS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> (!in_valid_ff && !out_valid_ff), "not empty")

endmodule

### verif/quadruped_creep_gait_sequencer_tb.sv
// Self-checking testbench for the creep gait sequencer.
//
// A gait model inside this module tracks the foot offsets, the raised leg, the walking
// direction and the position in the six-action cycle. Each item that the block accepts
// is applied to the model at the same edge. Every tick item yields one expected pose,
// which is queued. A checker takes each pose that the block hands over and compares it,
// angle by angle, with the oldest queued pose.
//
// The run opens with short directed tests: the reset pose, the knee limits, and the
// direction codes. A long hold setting follows, then a foot walk-out that drives the
// hips into their clamps, and a back-pressure test. Random walking phases under
// several register settings close the run.
module quadruped_creep_gait_sequencer_tb;
   import qcgs_pkg::*;

   // Angles and distances of the gait, in degrees and millimeters.
   localparam int HIP_MID     = 90;
   localparam int HIP_MIN     = 10;
   localparam int HIP_MAX     = 170;
   localparam int SHIFT_STEP  = 20;
   localparam int SWING_REACH = 40;
   localparam int FOOT_MAX    = 120;
   localparam int KNEE_LIFT   = 30;
   localparam int KNEE_CAP    = 85;

   // Legs 1 and 2 sit on the right side, so their hips turn against the foot offset.
   localparam logic [LEG_COUNT-1:0] LEG_MIRRORED = 4'b0110;
   // The cycle is: step leg 3, step leg 0, shift, step leg 1, step leg 2, shift.
   localparam logic [ACTION_COUNT-1:0] SHIFT_ACTIONS = 6'b100100;
   localparam logic [ACTION_COUNT-1:0][2:0] STEP_LEG =
      {3'd0, 3'd2, 3'd1, 3'd0, 3'd0, 3'd3};

   // Register indexes above the hold register are not backed by anything.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = CSR_HOLD_TICKS + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = '1;

   // The block holds an item in its input register and a pose in its result register. A
   // set-direction item sends back no pose, so a settle wait follows the drain.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 280;
   localparam int PHASE_COUNT   = 4;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_style_type;

   logic clock;
   logic reset;

   qcgs_req_if req_bus ();
   qcgs_rsp_if rsp_bus ();
   qcgs_csr_if csr_bus ();

   quadruped_creep_gait_sequencer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Gait model state and its copy of the registers.
   int          foot_mm [LEG_COUNT];
   leg_type     raised_at;
   dir_type     heading;
   int          action_at;
   substep_type substep_at;
   int          hold_left;
   angle_type   planted_knee [LEG_COUNT];
   angle_type   hold_setting;

   // Poses that the block still owes, oldest first.
   pose_type expected_poses [$];

   int items_sent;
   int poses_checked;
   int reg_writes;
   int settings_used;
   int mismatches;
   int stray_poses;

   // Pacing of both sides. The sender works in bursts while tx_gaps is set. The receiver
   // follows rx_style, and it holds off as long as holdoff_request asks once that is set.
   rx_style_type rx_style;
   bit           tx_gaps;
   int           burst_left;
   int           holdoff_request;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- gait model

   function automatic void gait_reset();
      for (int i = 0; i < LEG_COUNT; i++) begin
         foot_mm[i]      = 0;
         planted_knee[i] = STAND_KNEE_RESET;
      end
      hold_setting = HOLD_TICKS_RESET;
      raised_at    = NO_LEG;
      heading      = DIR_STOP;
      action_at    = 0;
      substep_at   = SUB_LIFT;
      hold_left    = 0;
   endfunction

   function automatic void gait_write_reg(input logic [CSR_INDEX_W-1:0] idx,
                                          input angle_type value);
      if (idx <= CSR_STAND_KNEE_LEG3) begin
         planted_knee[idx] = value;
      end else if (idx == CSR_HOLD_TICKS) begin
         hold_setting = value;
      end
   endfunction

   // The pose of all four legs as the model stands now.
   function automatic pose_type render_pose(input logic moving);
      pose_type p;
      int       hip;
      int       knee;
      for (int i = 0; i < LEG_COUNT; i++) begin
         hip = LEG_MIRRORED[i] ? HIP_MID - foot_mm[i] : HIP_MID + foot_mm[i];
         if (hip < HIP_MIN) begin
            hip = HIP_MIN;
         end else if (hip > HIP_MAX) begin
            hip = HIP_MAX;
         end
         knee = int'(planted_knee[i]);
         // A lifted knee saturates, even below a high planted angle.
         if (raised_at == i) begin
            knee = knee + KNEE_LIFT;
            if (knee > KNEE_CAP) begin
               knee = KNEE_CAP;
            end
         end
         p.hip[i]  = angle_type'(hip);
         p.knee[i] = angle_type'(knee);
      end
      p.walking = moving;
      return p;
   endfunction

   // Applies one item to the model. Returns 1 and the pose when the item is a tick.
   function automatic bit gait_apply(input logic cmd, input logic [1:0] code,
                                     output pose_type pose);
      int      pace;
      int      foot;
      leg_type leg;
      logic    shift_now;
      pose = '0;
      if (cmd == CMD_SET_DIR) begin
         // Only a start from standstill restarts the cycle; a change of direction or
         // a stop keeps the cycle position. Code -2 counts as backward.
         if (heading == DIR_STOP && code != DIR_STOP) begin
            action_at  = 0;
            substep_at = SUB_LIFT;
            hold_left  = 0;
         end
         heading = (code == DIR_FWD || code == DIR_STOP) ? dir_type'(code) : DIR_BACK;
         return 1'b0;
      end
      // Standing still: the raised leg comes down and nothing else moves.
      if (heading == DIR_STOP) begin
         raised_at = NO_LEG;
         pose = render_pose(1'b0);
         return 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         pose = render_pose(1'b1);
         return 1'b1;
      end
      pace      = (heading == DIR_FWD) ? 1 : -1;
      shift_now = SHIFT_ACTIONS[action_at];
      leg       = STEP_LEG[action_at];
      if (shift_now) begin
         for (int i = 0; i < LEG_COUNT; i++) begin
            foot = foot_mm[i] - pace * SHIFT_STEP;
            foot_mm[i] = (foot > FOOT_MAX) ? FOOT_MAX : (foot < -FOOT_MAX) ? -FOOT_MAX : foot;
         end
      end else if (substep_at == SUB_LIFT) begin
         raised_at = leg;
      end else if (substep_at == SUB_SWING) begin
         foot_mm[leg] = (pace > 0) ? SWING_REACH : -SWING_REACH;
      end else begin
         raised_at = NO_LEG;
      end
      pose = render_pose(1'b1);
      hold_left = int'(hold_setting);
      if (shift_now || substep_at == SUB_PLANT) begin
         substep_at = SUB_LIFT;
         action_at  = (action_at == ACTION_COUNT - 1) ? 0 : action_at + 1;
      end else begin
         substep_at = substep_at + 2'd1;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- result checking

   function automatic void note_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("pose %0d, %s: expected %0d, actual %0d", poses_checked, name, want, got);
         end
      end
   endfunction

   // Values are read just after the edge, before the block's registers update, so they
   // are the values that the handshake at that edge moved.
   always @(posedge clock) begin : check_poses
      pose_type want;
      pose_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.hip[0]  = rsp_bus.hip_leg0;
         got.hip[1]  = rsp_bus.hip_leg1;
         got.hip[2]  = rsp_bus.hip_leg2;
         got.hip[3]  = rsp_bus.hip_leg3;
         got.knee[0] = rsp_bus.knee_leg0;
         got.knee[1] = rsp_bus.knee_leg1;
         got.knee[2] = rsp_bus.knee_leg2;
         got.knee[3] = rsp_bus.knee_leg3;
         got.walking = rsp_bus.walking;
         if (expected_poses.size() == 0) begin
            stray_poses++;
            $display("pose arrived with none expected");
         end else begin
            want = expected_poses.pop_front();
            for (int i = 0; i < LEG_COUNT; i++) begin
               note_field($sformatf("hip_leg%0d", i), int'(want.hip[i]), int'(got.hip[i]));
               note_field($sformatf("knee_leg%0d", i), int'(want.knee[i]), int'(got.knee[i]));
            end
            note_field("walking", int'(want.walking), int'(got.walking));
         end
         poses_checked++;
      end
   end

   // The receiver. A long hold-off is counted here, cycle by cycle, while the sender
   // goes on offering items.
   initial begin : receiver
      int run_left;
      int stall_left;
      int hold_count;
      run_left   = 0;
      stall_left = 0;
      hold_count = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request > 0) begin
            hold_count      = holdoff_request;
            holdoff_request = 0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_style)
               RX_ALWAYS: begin
                  rsp_bus.ready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_bus.ready <= ($urandom_range(0, 99) >= 30);
               end
               default: begin
                  if (run_left > 0) begin
                     run_left--;
                     rsp_bus.ready <= 1'b1;
                  end else if (stall_left > 0) begin
                     stall_left--;
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     run_left   = $urandom_range(1, 12);
                     stall_left = $urandom_range(1, 10);
                     rsp_bus.ready <= 1'b0;
                  end
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Offers one item and waits until the block takes it. Valid stays high afterwards, so
   // that the next item can follow at once; a gap or a drain lowers it.
   task automatic send_item(input logic cmd, input logic [1:0] code);
      pose_type want;
      if (!req_bus.valid) begin
         req_bus.valid <= 1'b1;
      end
      req_bus.cmd       <= cmd;
      req_bus.direction <= code;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (gait_apply(cmd, code, want)) begin
         expected_poses.push_back(want);
      end
   endtask

   task automatic idle_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Called after each item: ends the current burst with a random gap when gaps are on.
   task automatic pace_sender();
      if (tx_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 15);
            idle_sender($urandom_range(1, 6));
         end
      end
   endtask

   // The sender pauses until every owed pose has come back.
   task automatic wait_drain();
      if (req_bus.valid) begin
         req_bus.valid <= 1'b0;
      end
      while (expected_poses.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input angle_type value);
      if (!csr_bus.valid) begin
         csr_bus.valid <= 1'b1;
      end
      csr_bus.index <= idx;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      reg_writes++;
      gait_write_reg(idx, value);
   endtask

   // Writes all registers once the block is idle. Knee leg i sits in knees[i]. Now and
   // then a spare index is written too; the block has to ignore it.
   task automatic configure(input angle_type [LEG_COUNT-1:0] knees, input angle_type hold);
      wait_idle();
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         write_reg(CSR_INDEX_W'(CSR_STAND_KNEE_LEG0 + leg), knees[leg]);
      end
      write_reg(CSR_HOLD_TICKS, hold);
      if ($urandom_range(0, 1) == 1) begin
         write_reg(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                   angle_type'($urandom_range(0, 255)));
      end
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic angle_type [LEG_COUNT-1:0] random_knees(input int top);
      angle_type [LEG_COUNT-1:0] knees;
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         knees[leg] = angle_type'($urandom_range(0, top));
      end
      return knees;
   endfunction

   task automatic send_ticks(input int count);
      repeat (count) begin
         send_item(CMD_TICK, 2'($urandom_range(0, 3)));
         pace_sender();
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Out of reset the robot stands: centered hips, knees at 60, walking low. A stop
   // while already stopped changes nothing.
   task automatic test_reset_pose();
      rx_style = RX_ALWAYS;
      tx_gaps  = 1'b0;
      send_ticks(2);
      send_item(CMD_SET_DIR, DIR_STOP);
      send_ticks(1);
   endtask

   // Knees at 0, 55, 255 and 180 lift to 30, 85, 85 and 85. For the last two, the
   // lifted knee ends up below the planted one. One full cycle lifts every leg once.
   // The spare register indexes are written with junk first.
   task automatic test_knee_limits();
      wait_idle();
      for (int idx = int'(CSR_SPARE_FIRST); idx <= int'(CSR_SPARE_LAST); idx++) begin
         write_reg(CSR_INDEX_W'(idx), 8'hff);
      end
      csr_bus.valid <= 1'b0;
      configure({8'd180, 8'd255, 8'd55, 8'd0}, 8'd0);
      send_item(CMD_SET_DIR, DIR_FWD);
      send_ticks(2 * ACTION_COUNT + 2);
   endtask

   // Code -2 while walking means backward and does not restart the cycle. A stop keeps
   // the cycle position, and a stopped tick plants the raised leg. A start from
   // standstill restarts the cycle.
   task automatic test_direction_codes();
      send_item(CMD_SET_DIR, 2'b10);
      send_ticks(2);
      send_item(CMD_SET_DIR, DIR_BACK);
      send_item(CMD_SET_DIR, DIR_STOP);
      send_ticks(1);
      send_item(CMD_SET_DIR, DIR_FWD);
      send_ticks(2);
   endtask

   // With the largest hold, each substep is followed by 255 repeated poses.
   task automatic test_long_hold();
      configure(random_knees(180), 8'd255);
      rx_style = RX_RANDOM;
      send_item(CMD_SET_DIR, DIR_FWD);
      send_ticks(258);
   endtask

   // Each round restarts the cycle from standstill and stops right after the first shift.
   // Legs 1 and 2 are never stepped, so their feet creep out to the foot limit and their
   // hips hit the clamp. Backward rounds push them one way, forward rounds the other.
   task automatic test_foot_clamp();
      configure(random_knees(255), 8'd0);
      tx_gaps = 1'b1;
      send_item(CMD_SET_DIR, DIR_STOP);
      for (int round = 0; round < 20; round++) begin
         send_item(CMD_SET_DIR, (round < 7) ? DIR_BACK : DIR_FWD);
         send_ticks(7);
         send_item(CMD_SET_DIR, DIR_STOP);
         pace_sender();
      end
   endtask

   // The receiver holds off for a long stretch while ticks keep coming, so the block
   // fills and stalls its input. The sender then pauses until every pose is back.
   task automatic test_backpressure();
      configure(random_knees(255), 8'd1);
      rx_style = RX_ALWAYS;
      tx_gaps  = 1'b0;
      send_item(CMD_SET_DIR, DIR_FWD);
      holdoff_request = 300;
      send_ticks(60);
      wait_drain();
      rx_style = RX_BURSTY;
      send_ticks(20);
   endtask

   // Mostly ticks with random direction changes, plus restart sequences from standstill.
   // Each phase changes the registers and the pacing of both sides.
   task automatic test_random_walk();
      int phase_end;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               configure('0, 8'd0);
               rx_style = RX_RANDOM;
               tx_gaps  = 1'b1;
            end
            1: begin
               configure(random_knees(255), 8'd1);
               rx_style = RX_BURSTY;
               tx_gaps  = 1'b1;
            end
            2: begin
               configure('1, angle_type'($urandom_range(0, 3)));
               rx_style = RX_ALWAYS;
               tx_gaps  = 1'b0;
            end
            default: begin
               configure(random_knees(180), 8'd2);
               rx_style = RX_RANDOM;
               tx_gaps  = 1'b1;
            end
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            if ($urandom_range(0, 99) < 8) begin
               send_item(CMD_SET_DIR, DIR_STOP);
               send_item(CMD_SET_DIR, 2'($urandom_range(1, 3)));
               send_ticks($urandom_range(3, 14));
            end else if ($urandom_range(0, 99) < 85) begin
               send_ticks(1);
            end else begin
               send_item(CMD_SET_DIR, 2'($urandom_range(0, 3)));
               pace_sender();
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      items_sent      = 0;
      poses_checked   = 0;
      reg_writes      = 0;
      settings_used   = 0;
      mismatches      = 0;
      stray_poses     = 0;
      burst_left      = 0;
      holdoff_request = 0;
      rx_style        = RX_ALWAYS;
      tx_gaps         = 1'b0;
      gait_reset();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_TICK;
      req_bus.direction <= DIR_STOP;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_STAND_KNEE_LEG0;
      csr_bus.wdata     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_pose();
      test_knee_limits();
      test_direction_codes();
      test_long_hold();
      test_foot_clamp();
      test_backpressure();
      test_random_walk();
      wait_idle();

      $display("Sent %0d items and checked %0d poses over %0d register settings (%0d writes).",
               items_sent, poses_checked, settings_used, reg_writes);
      $display("Wrong fields: %0d, poses with none expected: %0d, poses never received: %0d.",
               mismatches, stray_poses, expected_poses.size());
      if (mismatches == 0 && stray_poses == 0 && expected_poses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Safety net for a hung handshake. A correct run takes well under a tenth of this.
   initial begin : watchdog
      #5000000;
      $display("Timeout: the run did not finish.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### quadruped_creep_gait_sequencer.f
+incdir+rtl
rtl/qcgs_pkg.sv
rtl/qcgs_if.sv
rtl/qcgs_step.sv
rtl/qcgs_render.sv
rtl/quadruped_creep_gait_sequencer.sv
verif/quadruped_creep_gait_sequencer_tb.sv
